// ----- rtl/rpm_pkg.sv -----
// ----------------------------------------------------------------------------
// rpm_pkg
// Types and constants for the randomized Prim maze generator.
// ----------------------------------------------------------------------------
package rpm_pkg;

  localparam int GRID_SIDE_DEF      = 64;
  localparam int FRONTIER_DEPTH_DEF = 1024;

  localparam logic [1:0] CELL_UNVISITED = 2'd0;
  localparam logic [1:0] CELL_PASSAGE   = 2'd1;
  localparam logic [1:0] CELL_FRONTIER  = 2'd2;
  localparam logic [1:0] CELL_BORDER    = 2'd3;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_EXPAND = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] pick;
    logic [5:0] read_col;
    logic [5:0] read_row;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  cell_col;
    logic [5:0]  cell_row;
    logic [5:0]  wall_col;
    logic [5:0]  wall_row;
    logic        wall_carved;
    logic [2:0]  added;
    logic [10:0] remaining;
    logic        finished;
    logic [1:0]  cell_state;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_RD_ENT,
    ST_WT_ENT,
    ST_CARVE,
    ST_NB_RD,
    ST_NB_WT,
    ST_NB_DO,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD_WT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/randomized_prim_maze_generator.sv -----
// ----------------------------------------------------------------------------
// randomized_prim_maze_generator
// Prim maze generator: grid and frontier list held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Operation: start rewrites one grid cell per cycle, GRID_SIDE^2 cells, then
//   seeds the frontier; read looks up one grid cell; a rejected pick or kind
//   three goes straight to the result; expand also moves each frontier entry
//   behind the picked one down by one place (order kept, one RAM port).
// One item in flight; the next start is taken in the result cycle. Result
//   strobes for one cycle; the receiver cannot stall.
// Reset: sync, active high; grid reads as zero until the first start.
module randomized_prim_maze_generator #(
  parameter int GRID_SIDE      = rpm_pkg::GRID_SIDE_DEF,
  parameter int FRONTIER_DEPTH = rpm_pkg::FRONTIER_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rpm_pkg::in_word_t item,
  output logic              busy,
  output logic              done,
  output rpm_pkg::out_word_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [5:0]        cfg_data
);
  import rpm_pkg::*;

  localparam int CW = $clog2(GRID_SIDE);
  localparam int GA = 2 * CW;
  localparam int FW = $clog2(FRONTIER_DEPTH);
  localparam int NW = FW + 1;
  localparam int EW = 4 * CW;

  // grid memory
  logic [1:0]    grid_mem [GRID_SIDE*GRID_SIDE];
  logic          g_we;
  logic [GA-1:0] g_waddr, g_raddr;
  logic [1:0]    g_wdata, g_rdata;
  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_waddr] <= g_wdata;
    g_rdata <= grid_mem[g_raddr];
  end

  // frontier memory
  logic [EW-1:0] f_mem [FRONTIER_DEPTH];
  logic          f_we;
  logic [FW-1:0] f_waddr, f_raddr;
  logic [EW-1:0] f_wdata, f_rdata;
  always_ff @(posedge clk) begin
    if (f_we) f_mem[f_waddr] <= f_wdata;
    f_rdata <= f_mem[f_raddr];
  end

  state_t        state, state_next;
  logic [5:0]    maze_w, maze_h;
  logic [NW-1:0] count, count_next;
  logic          gvalid, gvalid_next;   // grid written since reset
  logic [GA:0]   clr, clr_next;
  in_word_t      cur, cur_next;
  logic [CW+1:0] px, py, qx, qy, wx, wy, px_next, py_next, qx_next, qy_next;
  logic [CW+1:0] wx_next, wy_next;
  logic          carved, carved_next;
  logic [1:0]    dir, dir_next;
  logic          nb_ph, nb_ph_next;      // 0 reading neighbour, 1 reading wall
  logic [1:0]    nb_val, nb_val_next;
  logic [2:0]    nadd, nadd_next;
  logic [NW-1:0] sh, sh_next;
  logic          stat, stat_next;
  out_word_t     res_next;
  logic          done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      maze_w <= 6'd62;
      maze_h <= 6'd62;
      count  <= '0;
      gvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      gvalid <= gvalid_next;
      done   <= done_next;
      if (cfg_we && cfg_index == REG_WIDTH)  maze_w <= cfg_data;
      if (cfg_we && cfg_index == REG_HEIGHT) maze_h <= cfg_data;
    end
    clr <= clr_next; cur <= cur_next; px <= px_next; py <= py_next;
    qx <= qx_next; qy <= qy_next; wx <= wx_next; wy <= wy_next;
    carved <= carved_next; dir <= dir_next; nb_ph <= nb_ph_next;
    nb_val <= nb_val_next; nadd <= nadd_next; sh <= sh_next;
    stat <= stat_next; result <= res_next;
  end

  assign busy = (state != ST_IDLE);

  // padded-grid coordinate in range (values carry 2 extra bits for sign/overflow)
  function automatic logic on_grid(input logic [CW+1:0] v);
    return v[CW+1:CW] == 2'b00;
  endfunction

  logic [CW+1:0] cx, cy, clx, cly, mw, mh;
  logic [1:0]    clr_val;
  logic [CW+1:0] nx, ny, nwx, nwy;
  logic [1:0]    rd_val;

  always_comb begin
    clx = {2'b00, clr[CW-1:0]};
    cly = {2'b00, clr[GA-1:CW]};
    mw  = (CW + 2)'(maze_w);
    mh  = (CW + 2)'(maze_h);
    clr_val = CELL_UNVISITED;
    if (clx > mw + 1 || cly > mh + 1 || clx == 1 || clx == mw || cly == 1 || cly == mh)
      clr_val = CELL_BORDER;
    cx = {2'b00, f_rdata[EW-1 -: CW]};
    cy = {2'b00, f_rdata[3*CW-1 -: CW]};
    case (dir)
      2'd0:    begin nx = px; ny = py - 2; nwx = px; nwy = py - 1; end
      2'd1:    begin nx = px + 2; ny = py; nwx = px + 1; nwy = py; end
      2'd2:    begin nx = px; ny = py + 2; nwx = px; nwy = py + 1; end
      default: begin nx = px - 2; ny = py; nwx = px - 1; nwy = py; end
    endcase
    rd_val = gvalid ? g_rdata : CELL_UNVISITED;
  end

  always_comb begin
    state_next = state; count_next = count; gvalid_next = gvalid;
    clr_next = clr; cur_next = cur; px_next = px; py_next = py;
    qx_next = qx; qy_next = qy; wx_next = wx; wy_next = wy;
    carved_next = carved; dir_next = dir; nb_ph_next = nb_ph;
    nb_val_next = nb_val; nadd_next = nadd; sh_next = sh;
    stat_next = stat; res_next = result; done_next = 1'b0;
    g_we = 1'b0; g_waddr = '0; g_wdata = CELL_UNVISITED; g_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_raddr = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cur_next = item; stat_next = 1'b0;
          carved_next = 1'b0; nadd_next = '0; px_next = '0; py_next = '0;
          wx_next = '0; wy_next = '0;
          case (item.kind)
            KIND_START:  begin clr_next = '0; state_next = ST_CLEAR; end
            KIND_EXPAND: begin
              if ((NW)'(item.pick) >= count || item.pick > 10'(FRONTIER_DEPTH - 1)) begin
                stat_next = 1'b1; state_next = ST_DONE;
              end else begin
                state_next = ST_RD_ENT;
              end
            end
            KIND_READ:   state_next = ST_RD_WT;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        g_we = 1'b1; g_waddr = clr[GA-1:0]; g_wdata = clr_val;
        clr_next = clr + 1'b1;
        if (clr[GA-1:0] == '1) state_next = ST_SEED;
      end
      ST_SEED: begin
        gvalid_next = 1'b1;
        f_we = 1'b1; f_waddr = '0;
        f_wdata = {CW'(2), CW'(2), CW'(2), CW'(2)};
        count_next = (NW)'(1);
        state_next = ST_DONE;
      end
      ST_RD_ENT: begin
        f_raddr = FW'(cur.pick);
        state_next = ST_WT_ENT;
      end
      ST_WT_ENT: begin
        px_next = cx; py_next = cy;
        qx_next = {2'b00, f_rdata[2*CW-1 -: CW]};
        qy_next = {2'b00, f_rdata[CW-1:0]};
        state_next = ST_CARVE;
      end
      ST_CARVE: begin
        // cell becomes passage here; the wall follows in ST_NB_RD via the carved flag
        g_we = 1'b1; g_waddr = {py[CW-1:0], px[CW-1:0]}; g_wdata = CELL_PASSAGE;
        carved_next = 1'b1;
        if (qy < py)      begin wx_next = px; wy_next = py - 1; end
        else if (qx > px) begin wx_next = px + 1; wy_next = py; end
        else if (qy > py) begin wx_next = px; wy_next = py + 1; end
        else if (qx < px) begin wx_next = px - 1; wy_next = py; end
        else carved_next = 1'b0;
        dir_next = 2'd0; nb_ph_next = 1'b0;
        state_next = ST_NB_RD;
      end
      ST_NB_RD: begin
        // first visit also writes the carved wall
        if (carved && dir == 2'd0 && !nb_ph && on_grid(wx) && on_grid(wy)) begin
          g_we = 1'b1; g_waddr = {wy[CW-1:0], wx[CW-1:0]}; g_wdata = CELL_PASSAGE;
        end
        g_raddr = nb_ph ? {nwy[CW-1:0], nwx[CW-1:0]} : {ny[CW-1:0], nx[CW-1:0]};
        state_next = ST_NB_WT;
      end
      ST_NB_WT: begin
        if (!nb_ph) begin
          nb_val_next = (on_grid(nx) && on_grid(ny)) ? rd_val : CELL_BORDER;
          nb_ph_next = 1'b1;
          state_next = ST_NB_RD;
        end else begin
          nb_val_next = (nb_val == CELL_UNVISITED &&
                         !(!(on_grid(nwx) && on_grid(nwy)) || rd_val == CELL_BORDER))
                        ? CELL_FRONTIER : CELL_BORDER;
          state_next = ST_NB_DO;
        end
      end
      ST_NB_DO: begin
        if (nb_val == CELL_FRONTIER && count < (NW)'(FRONTIER_DEPTH)) begin
          g_we = 1'b1; g_waddr = {ny[CW-1:0], nx[CW-1:0]}; g_wdata = CELL_FRONTIER;
          f_we = 1'b1; f_waddr = count[FW-1:0];
          f_wdata = {nx[CW-1:0], ny[CW-1:0], px[CW-1:0], py[CW-1:0]};
          count_next = count + 1'b1;
          nadd_next = nadd + 1'b1;
        end
        nb_ph_next = 1'b0;
        dir_next = dir + 1'b1;
        if (dir == 2'd3) begin
          sh_next = (NW)'(cur.pick);
          state_next = ST_SH_RD;
        end else begin
          state_next = ST_NB_RD;
        end
      end
      ST_SH_RD: begin
        if (sh + 1'b1 >= count) begin
          count_next = count - 1'b1;
          state_next = ST_DONE;
        end else begin
          f_raddr = FW'(sh + 1'b1);
          state_next = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        f_we = 1'b1; f_waddr = sh[FW-1:0]; f_wdata = f_rdata;
        sh_next = sh + 1'b1;
        state_next = ST_SH_RD;
      end
      ST_RD_WT: begin
        // address presented here, data next cycle
        g_raddr = {CW'(cur.read_row), CW'(cur.read_col)};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        done_next = 1'b1;
        res_next = '0;
        res_next.status = stat;
        res_next.remaining = 11'(count);
        res_next.finished = (count == '0);
        if (cur.kind == KIND_EXPAND && !stat) begin
          res_next.cell_col = 6'(px); res_next.cell_row = 6'(py);
          res_next.wall_carved = carved;
          res_next.wall_col = carved ? 6'(wx) : 6'd0;
          res_next.wall_row = carved ? 6'(wy) : 6'd0;
          res_next.added = nadd;
        end
        if (cur.kind == KIND_READ)
          res_next.cell_state = ((9'(cur.read_col) >= 9'(GRID_SIDE)) ||
                                 (9'(cur.read_row) >= 9'(GRID_SIDE))) ? CELL_BORDER : rd_val;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  unused_chk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item not taken");
  done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (NW)'(FRONTIER_DEPTH))
    else $error("frontier count overflow");
  cnt_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NB_DO) |=> (count == $past(count) || count == $past(count) + 1'b1))
    else $error("frontier count jumped");

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Maze generator check: start, expand and read words driven through the
// command port, each result compared against a grid/frontier predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import rpm_pkg::*;

  localparam int GSIDE = 64;
  localparam int FDEPTH = 1024;
  localparam int CYCLE_LIMIT = 12000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_word_t item = '0;
  logic busy, done;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_WIDTH;
  logic [5:0] cfg_data = '0;

  randomized_prim_maze_generator u_dut (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [1:0] maze [GSIDE*GSIDE];
  int fx [FDEPTH], fy [FDEPTH], fpx [FDEPTH], fpy [FDEPTH];
  int fcount;
  int mw, mh;

  in_word_t pending_q[$];
  out_word_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int n_sent = 0, n_checked = 0, n_expands = 0, n_finished = 0;

  function automatic void add_expected(out_word_t w);
    expected_q = {expected_q, w};
  endfunction

  function automatic logic [1:0] cell_at(int x, int y);
    if (x < 0 || y < 0 || x >= GSIDE || y >= GSIDE) return CELL_BORDER;
    return maze[y*GSIDE + x];
  endfunction

  function automatic void cell_set(int x, int y, logic [1:0] v);
    if (x < 0 || y < 0 || x >= GSIDE || y >= GSIDE) return;
    maze[y*GSIDE + x] = v;
  endfunction

  function automatic int grow(int x, int y, int nx, int ny, int wx, int wy);
    if (cell_at(nx, ny) != CELL_UNVISITED || cell_at(wx, wy) == CELL_BORDER) return 0;
    if (fcount >= FDEPTH) return 0;
    cell_set(nx, ny, CELL_FRONTIER);
    fx[fcount] = nx; fy[fcount] = ny; fpx[fcount] = x; fpy[fcount] = y;
    fcount++;
    return 1;
  endfunction

  function automatic out_word_t maze_step(in_word_t w);
    out_word_t r;
    int x, y, px, py, wx, wy, n;
    r = '0;
    if (w.kind == KIND_START) begin
      for (int j = 0; j < GSIDE; j++)
        for (int i = 0; i < GSIDE; i++)
          cell_set(i, j, (i > mw+1 || j > mh+1 || i == 1 || i == mw || j == 1 || j == mh)
                   ? CELL_BORDER : CELL_UNVISITED);
      fx[0] = 2; fy[0] = 2; fpx[0] = 2; fpy[0] = 2;
      fcount = 1;
    end else if (w.kind == KIND_EXPAND) begin
      if (w.pick >= fcount) begin
        r.status = 1'b1;
      end else begin
        x = fx[w.pick]; y = fy[w.pick]; px = fpx[w.pick]; py = fpy[w.pick];
        wx = 0; wy = 0; n = 0;
        cell_set(x, y, CELL_PASSAGE);
        r.wall_carved = 1'b1;
        if (py < y) begin wx = x; wy = y-1; end
        else if (px > x) begin wx = x+1; wy = y; end
        else if (py > y) begin wx = x; wy = y+1; end
        else if (px < x) begin wx = x-1; wy = y; end
        else r.wall_carved = 1'b0;
        if (r.wall_carved) cell_set(wx, wy, CELL_PASSAGE);
        n += grow(x, y, x, y-2, x, y-1);
        n += grow(x, y, x+2, y, x+1, y);
        n += grow(x, y, x, y+2, x, y+1);
        n += grow(x, y, x-2, y, x-1, y);
        for (int k = w.pick; k < fcount-1; k++) begin
          fx[k] = fx[k+1]; fy[k] = fy[k+1]; fpx[k] = fpx[k+1]; fpy[k] = fpy[k+1];
        end
        fcount--;
        r.cell_col = x[5:0]; r.cell_row = y[5:0];
        if (r.wall_carved) begin r.wall_col = wx[5:0]; r.wall_row = wy[5:0]; end
        r.added = n[2:0];
      end
    end else if (w.kind == KIND_READ) begin
      r.cell_state = cell_at(w.read_col, w.read_row);
    end
    r.remaining = fcount[10:0];
    r.finished = (fcount == 0);
    return r;
  endfunction

  // driver: start held until accepted
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) begin
        add_expected(maze_step(item));
        n_sent <= n_sent + 1;
        if (item.kind == KIND_EXPAND) n_expands <= n_expands + 1;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          start <= 1'b1;
          item <= pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, result);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.finished) n_finished++;
        if (result !== e) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, result);
          if (result.status !== e.status) $display("  status");
          if (result.cell_col !== e.cell_col || result.cell_row !== e.cell_row)
            $display("  cell");
          if (result.wall_col !== e.wall_col || result.wall_row !== e.wall_row ||
              result.wall_carved !== e.wall_carved) $display("  wall");
          if (result.added !== e.added) $display("  added");
          if (result.remaining !== e.remaining || result.finished !== e.finished)
            $display("  remaining/finished");
          if (result.cell_state !== e.cell_state) $display("  cell_state");
          errors++;
        end
      end
    end
  end

  function automatic in_word_t mk(logic [1:0] k, int p, int c, int r);
    in_word_t w;
    w.kind = k; w.pick = p[9:0]; w.read_col = c[5:0]; w.read_row = r[5:0];
    return w;
  endfunction

  function automatic void queue_word(in_word_t w);
    pending_q = {pending_q, w};
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || start || busy || expected_q.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v[5:0];
    if (idx == REG_WIDTH) mw = v; else mh = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one maze: start, mostly in-range expands, some reads and noise
  task automatic queue_maze(int n);
    int cnt, r;
    cnt = 1;
    queue_word(mk(KIND_START, 0, 0, 0));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 75 && cnt > 0) begin
        queue_word(mk(KIND_EXPAND, $urandom_range(cnt-1), 0, 0));
        cnt += 1;  // rough guess, only shapes the picks
      end else if (r < 88) begin
        queue_word(mk(KIND_READ, 0, $urandom_range(mw+2 < 63 ? mw+2 : 63),
                      $urandom_range(mh+2 < 63 ? mh+2 : 63)));
      end else if (r < 96) begin
        queue_word(mk(KIND_EXPAND, $urandom_range(1023), 0, 0));
      end else begin
        queue_word(mk(2'($urandom_range(3)), $urandom_range(1023),
                      $urandom_range(63), $urandom_range(63)));
      end
    end
  endtask

  initial begin
    int sizes [8] = '{4, 62, 5, 7, 63, 0, 9, 6};
    for (int i = 0; i < GSIDE*GSIDE; i++) maze[i] = CELL_UNVISITED;
    fcount = 0; mw = 62; mh = 62;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty frontier, read before start, kind three, extremes
    queue_word(mk(KIND_EXPAND, 0, 0, 0));
    queue_word(mk(KIND_READ, 0, 63, 63));
    queue_word(mk(2'd3, 1023, 63, 63));
    queue_word(mk(KIND_START, 0, 0, 0));
    queue_word(mk(KIND_EXPAND, 1, 0, 0));
    queue_word(mk(KIND_EXPAND, 1023, 0, 0));
    queue_word(mk(KIND_EXPAND, 0, 0, 0));
    queue_word(mk(KIND_EXPAND, 0, 0, 0));
    queue_word(mk(KIND_EXPAND, 1, 0, 0));
    queue_word(mk(KIND_READ, 0, 2, 2));
    queue_word(mk(KIND_READ, 0, 1, 1));
    queue_word(mk(KIND_READ, 0, 0, 0));
    queue_word(mk(KIND_READ, 0, 63, 0));
    queue_word(mk(KIND_READ, 0, 21, 42));
    queue_word(mk(KIND_READ, 0, 42, 21));
    queue_word(mk(2'd3, 682, 42, 21));
    drain();

    // mazes left with under 40 frontier entries run to completion so finished and wall-less picks show up
    for (int s = 0; s < 8; s++) begin
      case (s % 4)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 0;
        default: idle_pct = 11;
      endcase
      write_reg(REG_WIDTH, sizes[s]);
      write_reg(REG_HEIGHT, sizes[(s+3) % 8]);
      queue_maze(s < 2 ? 50 : 65);
      drain();
      // finish the maze with always-valid picks
      while (fcount > 0 && fcount < 40) begin
        queue_word(mk(KIND_EXPAND, (fcount > 1) ? $urandom_range(fcount-1) : 0,
                      0, 0));
        drain();
      end
    end
    write_reg(REG_WIDTH, 62);
    write_reg(REG_HEIGHT, 62);
    drain();

    $display("%0d words sent, %0d checked, %0d expands, %0d finished results",
             n_sent, n_checked, n_expands, n_finished);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- randomized_prim_maze_generator.f -----
rtl/rpm_pkg.sv
rtl/randomized_prim_maze_generator.sv
tb/tb_top.sv
